>>> src/sequential_list_engine_assert.svh
// ----------------------------------------------------------------------------
// Sequential list engine assertion macros
// Concurrent assertion shorthands for the list engine, clocked on the rising
// edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_ENGINE_ASSERT_SVH
`define SEQUENTIAL_LIST_ENGINE_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define SLE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the following cycle
`define SLE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and default sizes of the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

   // Default sizes
   localparam int CAPACITY_DEF   = 128;
   localparam int DATA_WIDTH_DEF = 32;

   // Operation codes
   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_DELETE = 2'd2;
   localparam logic [1:0] OP_LOCATE = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // Index register commands
   localparam logic [2:0] IDX_HOLD = 3'd0;
   localparam logic [2:0] IDX_ZERO = 3'd1;
   localparam logic [2:0] IDX_LAST = 3'd2;
   localparam logic [2:0] IDX_POS  = 3'd3;
   localparam logic [2:0] IDX_INC  = 3'd4;
   localparam logic [2:0] IDX_DEC  = 3'd5;

   // Store write select
   localparam logic [1:0] WR_NONE = 2'd0;
   localparam logic [1:0] WR_UP   = 2'd1;
   localparam logic [1:0] WR_DOWN = 2'd2;
   localparam logic [1:0] WR_NEW  = 2'd3;

   // Length counter commands
   localparam logic [1:0] CNT_HOLD = 2'd0;
   localparam logic [1:0] CNT_CLR  = 2'd1;
   localparam logic [1:0] CNT_INC  = 2'd2;
   localparam logic [1:0] CNT_DEC  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  position;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] removed_value;
      logic [7:0]  found_position;
      logic [7:0]  list_length;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic       load;
      logic [2:0] idx_op;
      logic       mem_rd;
      logic [1:0] wr_sel;
      logic [1:0] cnt_op;
      logic       cap_removed;
      logic       set_found;
      logic       set_status;
      logic [1:0] status_code;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [1:0] op;
      logic       ins_bad;
      logic       del_bad;
      logic       full;
      logic       need_shift;
      logic       ins_last;
      logic       idx_lt_cnt;
      logic       match;
   } stat_type;

endpackage

>>> src/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of up to CAPACITY elements with clear, insert, delete and
// locate, one result transaction per request transaction.
//
// Request channel (req_): op, 1-based position and value. Response channel
// (rsp_): status, removed value, found position and the new list length.
// One request is worked on at a time; the next is taken as soon as the
// previous result sits in the output register, even if not yet taken.
// Clear and rejected requests go straight to the result. Insert moves the
// elements from the end down to the position up one place, then writes the
// value; delete reads out the element, then moves the rest down; locate scans
// from the head for the first equal element. Each moved or compared element
// takes a store read, then a write or compare step. A stalled response holds
// its register and the block waits with the next finished result. Reset
// empties the list at once; the store contents are not cleared.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
   parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sle_pkg::rsp_type rsp_data
);
   import sle_pkg::*;

   `include "sequential_list_engine_assert.svh"

   cmd_type  cmd;
   stat_type stat;

   logic     req_fire;
   logic     status_legal;
   logic     rm_seen;
   logic     rm_clean;
   logic     cmd_single;

   sle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   sle_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

   // Terms for the checks
   assign req_fire     = req_valid && req_ready;
   assign status_legal = rsp_data.status inside {ST_OK, ST_RANGE, ST_FULL};
   assign rm_seen      = rsp_valid && (rsp_data.removed_value != 32'd0);
   assign rm_clean     = (rsp_data.status == ST_OK) && (rsp_data.found_position == 8'd0);
   assign cmd_single   = $onehot0({cmd.load, cmd.rsp_load, cmd.mem_rd});

   // Checks
   `SLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_ready, "ready after accept")
   `SLE_ASSERT_SAME(a_status_code, clock, reset, rsp_valid, status_legal, "bad status code")
   `SLE_ASSERT_SAME(a_removed_ok, clock, reset, rm_seen, rm_clean, "stray removed value")
   `SLE_ASSERT_SAME(a_single_cmd, clock, reset, 1'b1, cmd_single, "overlapping commands")

endmodule

>>> src/sle_dpath.sv
// ----------------------------------------------------------------------------
// sle_dpath
// Datapath of the list engine: element store, length counter, walk index,
// captured transaction and result registers.
// ----------------------------------------------------------------------------
module sle_dpath #(
   parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  sle_pkg::req_type  req_data,
   input  sle_pkg::cmd_type  cmd,
   output sle_pkg::stat_type stat,
   output sle_pkg::rsp_type  rsp_data
);
   import sle_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CMP_W  = ((CNT_W > 8) ? CNT_W : 8) + 1;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   logic [1:0]            op_ff;
   logic [7:0]            pos_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [1:0]            st_ff;
   logic [DATA_WIDTH-1:0] removed_ff;
   logic [CNT_W-1:0]      found_ff;
   rsp_type               rsp_ff;

   logic [DATA_WIDTH+31:0] val_ext;
   logic [DATA_WIDTH+31:0] removed_ext;
   logic [CNT_W+7:0]       found_ext;
   logic [CNT_W+7:0]       count_ext;
   logic [CMP_W-1:0]       pos_w, cnt_w, idx_w, pos_m1;
   logic [CNT_W-1:0]       idx_plus, idx_minus;
   logic [ADDR_W-1:0]      wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic                   wr_en;

   // Widen fields for compares and narrow them for the outputs
   assign val_ext     = {{DATA_WIDTH{1'b0}}, req_data.value};
   assign removed_ext = {32'd0, removed_ff};
   assign found_ext   = {8'd0, found_ff};
   assign count_ext   = {8'd0, count_ff};
   assign pos_w       = CMP_W'(pos_ff);
   assign cnt_w       = CMP_W'(count_ff);
   assign idx_w       = CMP_W'(idx_ff);
   assign pos_m1      = pos_w - CMP_W'(1);
   assign idx_plus    = idx_ff + CNT_W'(1);
   assign idx_minus   = idx_ff - CNT_W'(1);

   // Status toward the controller
   always_comb begin
      stat.op         = op_ff;
      stat.ins_bad    = (pos_ff == 8'd0) || (pos_w > (cnt_w + CMP_W'(1)));
      stat.del_bad    = (pos_ff == 8'd0) || (pos_w > cnt_w);
      stat.full       = (count_ff >= CNT_W'(CAPACITY));
      stat.need_shift = (pos_w <= cnt_w);
      stat.ins_last   = (idx_w == pos_m1);
      stat.idx_lt_cnt = (idx_ff < count_ff);
      stat.match      = (rd_data_ff == val_ff);
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_data.op;
         pos_ff <= req_data.position;
         val_ff <= val_ext[DATA_WIDTH-1:0];
      end
   end

   // Walk index
   always_comb begin
      case (cmd.idx_op)
         IDX_HOLD: idx_in = idx_ff;
         IDX_ZERO: idx_in = '0;
         IDX_LAST: idx_in = count_ff - CNT_W'(1);
         IDX_POS:  idx_in = pos_m1[CNT_W-1:0];
         IDX_INC:  idx_in = idx_plus;
         IDX_DEC:  idx_in = idx_minus;
         default:  idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
   end

   // Length counter
   always_comb begin
      case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_CLR:  count_in = '0;
         CNT_INC:  count_in = count_ff + CNT_W'(1);
         CNT_DEC:  count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Store write port
   always_comb begin
      wr_en   = 1'b1;
      wr_data = rd_data_ff;
      case (cmd.wr_sel)
         WR_NONE: begin
            wr_en   = 1'b0;
            wr_addr = idx_ff[ADDR_W-1:0];
         end
         WR_UP:   wr_addr = idx_plus[ADDR_W-1:0];
         WR_DOWN: wr_addr = idx_minus[ADDR_W-1:0];
         WR_NEW: begin
            wr_addr = pos_m1[ADDR_W-1:0];
            wr_data = val_ff;
         end
         default: begin
            wr_en   = 1'b0;
            wr_addr = idx_ff[ADDR_W-1:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Store read port, registered
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[idx_ff[ADDR_W-1:0]];
      end
   end

   // Per-transaction results, cleared on load
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         st_ff      <= ST_OK;
         removed_ff <= '0;
         found_ff   <= '0;
      end else begin
         if (cmd.set_status) begin
            st_ff <= cmd.status_code;
         end
         if (cmd.cap_removed) begin
            removed_ff <= rd_data_ff;
         end
         if (cmd.set_found) begin
            found_ff <= idx_plus;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_ff.status         <= st_ff;
         rsp_ff.removed_value  <= removed_ext[31:0];
         rsp_ff.found_position <= found_ext[7:0];
         rsp_ff.list_length    <= count_ext[7:0];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> src/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl
// Controller of the list engine: sequences each operation over the store
// and owns both handshakes.
// ----------------------------------------------------------------------------
module sle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  sle_pkg::stat_type stat,
   output sle_pkg::cmd_type  cmd
);
   import sle_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EXEC    = 4'd1;
   localparam logic [3:0] S_INS_RD  = 4'd2;
   localparam logic [3:0] S_INS_WR  = 4'd3;
   localparam logic [3:0] S_INS_PUT = 4'd4;
   localparam logic [3:0] S_DEL_RD  = 4'd5;
   localparam logic [3:0] S_DEL_CAP = 4'd6;
   localparam logic [3:0] S_DEL_CHK = 4'd7;
   localparam logic [3:0] S_DEL_SRD = 4'd8;
   localparam logic [3:0] S_DEL_SWR = 4'd9;
   localparam logic [3:0] S_LOC_CHK = 4'd10;
   localparam logic [3:0] S_LOC_RD  = 4'd11;
   localparam logic [3:0] S_LOC_CMP = 4'd12;
   localparam logic [3:0] S_FINISH  = 4'd13;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.op)
               OP_CLEAR: begin
                  cmd.cnt_op = CNT_CLR;
                  state_in   = S_FINISH;
               end
               OP_INSERT: begin
                  if (stat.ins_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_RANGE;
                     state_in        = S_FINISH;
                  end else if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                     state_in        = S_FINISH;
                  end else if (stat.need_shift) begin
                     cmd.idx_op = IDX_LAST;
                     state_in   = S_INS_RD;
                  end else begin
                     state_in = S_INS_PUT;
                  end
               end
               OP_DELETE: begin
                  if (stat.del_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_RANGE;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.idx_op = IDX_POS;
                     state_in   = S_DEL_RD;
                  end
               end
               default: begin
                  cmd.idx_op = IDX_ZERO;
                  state_in   = S_LOC_CHK;
               end
            endcase
         end
         // Move elements up one place, highest first
         S_INS_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.wr_sel = WR_UP;
            if (stat.ins_last) begin
               state_in = S_INS_PUT;
            end else begin
               cmd.idx_op = IDX_DEC;
               state_in   = S_INS_RD;
            end
         end
         S_INS_PUT: begin
            cmd.wr_sel = WR_NEW;
            cmd.cnt_op = CNT_INC;
            state_in   = S_FINISH;
         end
         // Take out the element, then move the rest down
         S_DEL_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_DEL_CAP;
         end
         S_DEL_CAP: begin
            cmd.cap_removed = 1'b1;
            cmd.idx_op      = IDX_INC;
            state_in        = S_DEL_CHK;
         end
         S_DEL_CHK: begin
            if (stat.idx_lt_cnt) begin
               state_in = S_DEL_SRD;
            end else begin
               cmd.cnt_op = CNT_DEC;
               state_in   = S_FINISH;
            end
         end
         S_DEL_SRD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_DEL_SWR;
         end
         S_DEL_SWR: begin
            cmd.wr_sel = WR_DOWN;
            cmd.idx_op = IDX_INC;
            state_in   = S_DEL_CHK;
         end
         // Scan from the head for the first equal element
         S_LOC_CHK: begin
            if (stat.idx_lt_cnt) begin
               state_in = S_LOC_RD;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_LOC_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_LOC_CMP;
         end
         S_LOC_CMP: begin
            if (stat.match) begin
               cmd.set_found = 1'b1;
               state_in      = S_FINISH;
            end else begin
               cmd.idx_op = IDX_INC;
               state_in   = S_LOC_CHK;
            end
         end
         // Hand the result to the output register once it is free
         S_FINISH: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> tb/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker
// Watches both channels of the list engine. Each request transaction is
// applied to a shadow copy of the list and the expected response is queued.
// Each response transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module sle_checker #(
   parameter int CAPACITY   = sle_pkg::CAPACITY_DEF,
   parameter int DATA_WIDTH = sle_pkg::DATA_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  sle_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  sle_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import sle_pkg::*;

   localparam logic [31:0] VALUE_MASK =
      (DATA_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << DATA_WIDTH) - 1);

   // Shadow list: packed elements and current length
   logic [31:0] shadow_elems [CAPACITY];
   int          shadow_len = 0;

   rsp_type     expected_rsp [$];
   int          mismatch_count = 0;
   int          pending = 0;

   assign fail_count    = mismatch_count;
   assign pending_count = pending;

   // Apply one operation to the shadow list and build its response
   function automatic rsp_type apply_list_op(input req_type req);
      rsp_type     r;
      int          pos;
      int          k;
      logic [31:0] v;
      r   = '0;
      pos = req.position;
      v   = req.value & VALUE_MASK;
      case (req.op)
         OP_CLEAR: begin
            shadow_len = 0;
         end
         OP_INSERT: begin
            if (pos < 1 || pos > shadow_len + 1) begin
               r.status = ST_RANGE;
            end else if (shadow_len >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (k = shadow_len; k >= pos; k--)
                  shadow_elems[k] = shadow_elems[k-1];
               shadow_elems[pos-1] = v;
               shadow_len++;
            end
         end
         OP_DELETE: begin
            if (pos < 1 || pos > shadow_len) begin
               r.status = ST_RANGE;
            end else begin
               r.removed_value = shadow_elems[pos-1];
               for (k = pos; k < shadow_len; k++)
                  shadow_elems[k-1] = shadow_elems[k];
               shadow_len--;
            end
         end
         default: begin
            // Locate: first equal element wins
            for (k = 0; k < shadow_len; k++) begin
               if (shadow_elems[k] == v) begin
                  r.found_position = 8'(k + 1);
                  break;
               end
            end
         end
      endcase
      r.list_length = 8'(shadow_len);
      return r;
   endfunction

   task automatic check_field(input string field_name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, field_name, want, got);
      end
   endtask

   // Predict on request transactions, compare on response transactions
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready)
            expected_rsp.push_back(apply_list_op(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, actual 0x%0h",
                        $time, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("removed_value", want.removed_value, rsp_data.removed_value);
               check_field("found_position", 32'(want.found_position),
                           32'(rsp_data.found_position));
               check_field("list_length", 32'(want.list_length),
                           32'(rsp_data.list_length));
            end
         end
         pending <= expected_rsp.size();
      end
   end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sequential list engine. A directed opening
// covers range errors, ends of the list, duplicates and clear; random phases
// then fill, grow, churn and drain the list or send it random noise, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import sle_pkg::*;

   localparam int LIST_CAP     = sle_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS = 800;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 2_000_000;

   typedef enum {PH_FILL, PH_GROW, PH_CHURN, PH_SHRINK, PH_NOISE} phase_kind_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int          stim_len = 0;
   logic [31:0] recent_values [$];
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   always #2 clock = ~clock;

   sequential_list_engine #(
      .CAPACITY   (LIST_CAP),
      .DATA_WIDTH (sle_pkg::DATA_WIDTH_DEF)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   sle_checker #(
      .CAPACITY   (LIST_CAP),
      .DATA_WIDTH (sle_pkg::DATA_WIDTH_DEF)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Abort on a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_type mk_req(input logic [1:0] op, input int pos,
                                      input logic [31:0] val);
      req_type r;
      r.op       = op;
      r.position = 8'(pos);
      r.value    = val;
      return r;
   endfunction

   // Track the list length so positions can be aimed at the valid range
   function automatic void track_length(input req_type r);
      int pos;
      pos = r.position;
      case (r.op)
         OP_CLEAR: stim_len = 0;
         OP_INSERT: begin
            if (pos >= 1 && pos <= stim_len + 1 && stim_len < LIST_CAP) begin
               stim_len++;
               recent_values.push_back(r.value);
               if (recent_values.size() > 32)
                  void'(recent_values.pop_front());
            end
         end
         OP_DELETE: if (pos >= 1 && pos <= stim_len) stim_len--;
         default: ;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return 32'($urandom_range(0, 7));
         4, 5, 6:    return $urandom;
         7:          return 32'h0;
         8:          return 32'hFFFF_FFFF;
         default: begin
            if (recent_values.size() == 0)
               return $urandom;
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
         end
      endcase
   endfunction

   // Insert position: mostly valid, biased to both ends
   function automatic int pick_insert_pos();
      if ($urandom_range(0, 99) < 85) begin
         case ($urandom_range(0, 3))
            0:       return 1;
            1:       return stim_len + 1;
            default: return $urandom_range(1, stim_len + 1);
         endcase
      end
      if ($urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(stim_len + 2, 255);
   endfunction

   function automatic int pick_delete_pos();
      if (stim_len > 0 && $urandom_range(0, 99) < 85) begin
         case ($urandom_range(0, 3))
            0:       return 1;
            1:       return stim_len;
            default: return $urandom_range(1, stim_len);
         endcase
      end
      if ($urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(stim_len + 1, 255);
   endfunction

   function automatic req_type make_item(input phase_kind_type kind);
      int          roll;
      int          ins_w;
      int          del_w;
      logic [1:0]  op;
      logic [31:0] val;
      roll = $urandom_range(0, 99);
      case (kind)
         PH_GROW:   begin ins_w = 70; del_w = 15; end
         PH_SHRINK: begin ins_w = 15; del_w = 70; end
         default:   begin ins_w = 40; del_w = 35; end
      endcase
      if (kind == PH_NOISE)
         return mk_req(2'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom);
      if (roll < ins_w)
         return mk_req(OP_INSERT, pick_insert_pos(), pick_value());
      if (roll < ins_w + del_w)
         return mk_req(OP_DELETE, pick_delete_pos(), $urandom);
      if (roll < 98) begin
         if (recent_values.size() > 0 && $urandom_range(0, 9) < 6)
            val = recent_values[$urandom_range(0, recent_values.size() - 1)];
         else
            val = pick_value();
         return mk_req(OP_LOCATE, $urandom_range(0, 255), val);
      end
      op = (kind == PH_SHRINK) ? OP_DELETE : OP_CLEAR;
      return mk_req(op, $urandom_range(0, 255), $urandom);
   endfunction

   // Present one request transaction after a random gap; hold until accepted
   task automatic send_request(input req_type item);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 19) : 0;
      track_length(item);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // Response side: stall a random number of cycles before each transaction
   initial begin
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 19) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   initial begin
      int             sent;
      int             phase_len;
      int             extra;
      phase_kind_type kind;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: range errors on an empty list, ends, duplicates, clear
      send_request(mk_req(OP_DELETE, 1, 32'h0));
      send_request(mk_req(OP_INSERT, 0, 32'h1111_1111));
      send_request(mk_req(OP_INSERT, 2, 32'h2222_2222));
      send_request(mk_req(OP_LOCATE, 0, 32'h0));
      send_request(mk_req(OP_INSERT, 1, 32'h0));
      send_request(mk_req(OP_INSERT, 1, 32'hFFFF_FFFF));
      send_request(mk_req(OP_INSERT, 3, 32'hA5A5_A5A5));
      send_request(mk_req(OP_INSERT, 2, 32'h0));
      send_request(mk_req(OP_LOCATE, 255, 32'h0));
      send_request(mk_req(OP_LOCATE, 1, 32'hFFFF_FFFF));
      send_request(mk_req(OP_LOCATE, 2, 32'h0001_2345));
      send_request(mk_req(OP_INSERT, 255, 32'h5A5A_5A5A));
      send_request(mk_req(OP_INSERT, 6, 32'h5A5A_5A5A));
      send_request(mk_req(OP_DELETE, 0, 32'hFFFF_FFFF));
      send_request(mk_req(OP_DELETE, 5, 32'h0));
      send_request(mk_req(OP_DELETE, 4, 32'h0));
      send_request(mk_req(OP_DELETE, 1, 32'h0));
      send_request(mk_req(OP_DELETE, 255, 32'h0));
      send_request(mk_req(OP_LOCATE, 0, 32'hA5A5_A5A5));
      send_request(mk_req(OP_CLEAR, 255, 32'hFFFF_FFFF));
      send_request(mk_req(OP_DELETE, 1, 32'h0));
      send_request(mk_req(OP_LOCATE, 128, 32'h0));
      send_request(mk_req(OP_CLEAR, 0, 32'h0));

      // Random phases; open with a fill so the full list is reached early
      sent = 0;
      kind = PH_FILL;
      while (sent < RANDOM_ITEMS) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         if (kind == PH_FILL) begin
            while (stim_len < LIST_CAP) begin
               send_request(mk_req(OP_INSERT, $urandom_range(1, stim_len + 1),
                                   pick_value()));
               sent++;
            end
            // Probe the full list at valid and invalid positions
            for (extra = 0; extra < 6; extra++) begin
               send_request(mk_req(OP_INSERT, pick_insert_pos(), pick_value()));
               sent++;
            end
            send_request(mk_req(OP_LOCATE, 0, $urandom));
            sent++;
         end else begin
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
               send_request(make_item(kind));
               sent++;
            end
         end
         case ($urandom_range(0, 9))
            0:       kind = PH_FILL;
            1, 2, 3: kind = PH_GROW;
            4, 5, 6: kind = PH_CHURN;
            7, 8:    kind = PH_SHRINK;
            default: kind = PH_NOISE;
         endcase
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then allow for stray ones
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
